/* rtl/ipsv_pkg.sv */
package ipsv_pkg;

   localparam int PERIOD_W     = 14;
   localparam int PERIOD_RESET = 100;
   localparam int SQRT3_Q14    = 28378;
   localparam int SQRT3_W      = 15;
   localparam int SQRT3_FRAC   = 14;
   localparam int TK_W         = PERIOD_W + SQRT3_W;
   localparam int VEC_W        = 20;
   localparam int CMP_W        = 18;
   localparam int SECTOR_W     = 3;
   localparam int RSP_BITS     = 3 * CMP_W + SECTOR_W;
   localparam int RSP_W        = ((RSP_BITS + 7) / 8) * 8;

   localparam logic [SECTOR_W-1:0] SECTOR_1 = 3'd1;
   localparam logic [SECTOR_W-1:0] SECTOR_2 = 3'd2;
   localparam logic [SECTOR_W-1:0] SECTOR_3 = 3'd3;
   localparam logic [SECTOR_W-1:0] SECTOR_4 = 3'd4;
   localparam logic [SECTOR_W-1:0] SECTOR_5 = 3'd5;
   localparam logic [SECTOR_W-1:0] SECTOR_6 = 3'd6;

   typedef logic signed [VEC_W-1:0] vec_type;
   typedef logic [SECTOR_W-1:0]     sector_type;

endpackage

/* rtl/ipsv_rotate.sv */
module ipsv_rotate #(
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             en,
   input  logic                             in_valid,
   input  logic signed [SAMPLE_WIDTH-1:0]   d_voltage,
   input  logic signed [SAMPLE_WIDTH-1:0]   q_voltage,
   input  logic signed [SAMPLE_WIDTH-1:0]   sine_value,
   input  logic signed [SAMPLE_WIDTH-1:0]   cosine_value,
   output logic                             out_valid,
   output logic signed [SAMPLE_WIDTH+1:0]   alpha,
   output logic signed [SAMPLE_WIDTH+1:0]   beta
);

   localparam int F       = SAMPLE_WIDTH - 1;
   localparam int PROD_W  = 2 * SAMPLE_WIDTH;
   localparam int ALPHA_W = SAMPLE_WIDTH + 2;

   logic                     v1_ff;
   logic                     v2_ff;
   logic signed [PROD_W-1:0] dc_ff, qs_ff, ds_ff, qc_ff;
   logic signed [PROD_W-1:0] dc_in, qs_in, ds_in, qc_in;
   logic signed [PROD_W-1:0] dc_sh, qs_sh, ds_sh, qc_sh;
   logic signed [ALPHA_W-1:0] alpha_ff, beta_ff, alpha_in, beta_in;

   // stage 1: the four rotation products
   assign dc_in = PROD_W'(d_voltage) * PROD_W'(cosine_value);
   assign qs_in = PROD_W'(q_voltage) * PROD_W'(sine_value);
   assign ds_in = PROD_W'(d_voltage) * PROD_W'(sine_value);
   assign qc_in = PROD_W'(q_voltage) * PROD_W'(cosine_value);

   // stage 2: floor shifts and sums
   assign dc_sh = dc_ff >>> F;
   assign qs_sh = qs_ff >>> F;
   assign ds_sh = ds_ff >>> F;
   assign qc_sh = qc_ff >>> F;
   assign alpha_in = ALPHA_W'(dc_sh) - ALPHA_W'(qs_sh);
   assign beta_in  = ALPHA_W'(ds_sh) + ALPHA_W'(qc_sh);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dc_ff    <= dc_in;
         qs_ff    <= qs_in;
         ds_ff    <= ds_in;
         qc_ff    <= qc_in;
         alpha_ff <= alpha_in;
         beta_ff  <= beta_in;
      end
   end

   assign out_valid = v2_ff;
   assign alpha     = alpha_ff;
   assign beta      = beta_ff;

endmodule

/* rtl/inverse_park_svpwm_duty.sv */
// Inverse Park transform and space vector PWM compare generation. Each request
// carries d/q voltage commands and the rotor angle's sine and cosine (signed
// Q1.(SAMPLE_WIDTH-1)); the response carries the three phase compare values,
// centered on half the period, and the sector 1..6. The block is a 7-stage
// pipeline: it takes one request per clock unless the output stalls. When
// the response is not taken the whole pipeline holds, so no request is lost.
// The period register is written over the csr port and must only change while
// no request is in flight.
module inverse_park_svpwm_duty
   import ipsv_pkg::*;
#(
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       req_tvalid,
   output logic                                       req_tready,
   // d_voltage, q_voltage, sine_value, cosine_value
   input  logic [((4*SAMPLE_WIDTH+7)/8)*8-1:0]        req_tdata,
   output logic                                       rsp_tvalid,
   input  logic                                       rsp_tready,
   // phase_a_compare, phase_b_compare, phase_c_compare, sector
   output logic [RSP_W-1:0]                           rsp_tdata,
   input  logic                                       csr_valid,
   output logic                                       csr_ready,
   input  logic [PERIOD_W-1:0]                        csr_data
);

   localparam int W       = SAMPLE_WIDTH;
   localparam int F       = W - 1;
   localparam int ALPHA_W = W + 2;
   localparam int UAP_W   = TK_W + 1 + ALPHA_W;
   localparam int UBP_W   = PERIOD_W + 2 + ALPHA_W;
   localparam int UA_SH   = F + SQRT3_FRAC;
   localparam int BASE_W  = PERIOD_W + 2;

   logic                       en;
   logic [PERIOD_W-1:0]        period_ff;
   logic [TK_W-1:0]            tk_ff;

   logic                       rot_valid;
   logic signed [ALPHA_W-1:0]  alpha, beta;

   logic                       v3_ff, v4_ff, v5_ff, v6_ff, v7_ff;

   logic signed [TK_W:0]       tk_s;
   logic signed [PERIOD_W:0]   t_s;
   logic signed [UAP_W-1:0]    ua_prod_ff, ua_prod_in, ua_bias, ua_sum, ua_shift;
   logic signed [UBP_W-1:0]    ub_prod_ff, ub_prod_in, ub_bias, ub_sum, ub_shift;

   vec_type                    ua_ff, ub_ff, ua_in, ub_in;
   vec_type                    x_ff, y_ff, z_ff, y_in, z_in, y_sum, z_sum;
   vec_type                    x6_ff, y6_ff, z6_ff, a_ff, a_in;
   vec_type                    p_sel, m_sel, a_num, b_in, c_in;
   sector_type                 sector_ff, sector_in, sector7_ff;
   logic [BASE_W-1:0]          base;

   logic [CMP_W-1:0]           cmp_a_ff, cmp_b_ff, cmp_c_ff;

   assign en         = !v7_ff || rsp_tready;
   assign req_tready = en;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= PERIOD_W'(PERIOD_RESET);
      end else if (csr_valid) begin
         period_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      tk_ff <= TK_W'(period_ff) * TK_W'(SQRT3_Q14);
   end

   // stages 1-2
   ipsv_rotate #(.SAMPLE_WIDTH(W)) u_rotate (
      .clock        (clock),
      .reset        (reset),
      .en           (en),
      .in_valid     (req_tvalid),
      .d_voltage    (req_tdata[0 +: W]),
      .q_voltage    (req_tdata[W +: W]),
      .sine_value   (req_tdata[2*W +: W]),
      .cosine_value (req_tdata[3*W +: W]),
      .out_valid    (rot_valid),
      .alpha        (alpha),
      .beta         (beta)
   );

   // stage 3: period and sqrt3 scaling
   assign tk_s       = {1'b0, tk_ff};
   assign t_s        = {1'b0, period_ff};
   assign ua_prod_in = UAP_W'(tk_s) * UAP_W'(alpha);
   assign ub_prod_in = -(UBP_W'(t_s) * UBP_W'(beta));

   // stage 4: shifts toward zero
   assign ua_bias  = ua_prod_ff[UAP_W-1] ? {{(UAP_W-UA_SH){1'b0}}, {UA_SH{1'b1}}} : '0;
   assign ua_sum   = ua_prod_ff + ua_bias;
   assign ua_shift = ua_sum >>> UA_SH;
   assign ua_in    = VEC_W'(ua_shift);
   assign ub_bias  = ub_prod_ff[UBP_W-1] ? {{(UBP_W-F){1'b0}}, {F{1'b1}}} : '0;
   assign ub_sum   = ub_prod_ff + ub_bias;
   assign ub_shift = ub_sum >>> F;
   assign ub_in    = VEC_W'(ub_shift);

   // stage 5: X, Y, Z
   assign y_sum = ua_ff + ub_ff;
   assign z_sum = ub_ff - ua_ff;
   assign y_in  = (y_sum + vec_type'({{(VEC_W-1){1'b0}}, y_sum[VEC_W-1]})) >>> 1;
   assign z_in  = (z_sum + vec_type'({{(VEC_W-1){1'b0}}, z_sum[VEC_W-1]})) >>> 1;

   // stage 6: sector and phase A
   always_comb begin
      if (y_ff < 0) begin
         if (z_ff < 0) begin
            sector_in = SECTOR_5;
         end else begin
            sector_in = (x_ff > 0) ? SECTOR_3 : SECTOR_4;
         end
      end else begin
         if (z_ff < 0) begin
            sector_in = (x_ff > 0) ? SECTOR_1 : SECTOR_6;
         end else begin
            sector_in = SECTOR_2;
         end
      end
   end

   always_comb begin
      case (sector_in)
         SECTOR_1, SECTOR_4: begin
            p_sel = x_ff;
            m_sel = z_ff;
         end
         SECTOR_2, SECTOR_5: begin
            p_sel = y_ff;
            m_sel = z_ff;
         end
         default: begin
            p_sel = y_ff;
            m_sel = x_ff;
         end
      endcase
   end

   assign base  = BASE_W'({period_ff[PERIOD_W-1:2], 1'b0}) + BASE_W'(period_ff[PERIOD_W-1:1]);
   assign a_num = vec_type'({{(VEC_W-BASE_W){1'b0}}, base}) + p_sel - m_sel;
   assign a_in  = (a_num + vec_type'({{(VEC_W-1){1'b0}}, a_num[VEC_W-1]})) >>> 1;

   // stage 7: phases B and C
   always_comb begin
      case (sector_ff)
         SECTOR_1, SECTOR_4: begin
            b_in = a_ff + z6_ff;
            c_in = b_in - x6_ff;
         end
         SECTOR_2, SECTOR_5: begin
            b_in = a_ff + z6_ff;
            c_in = a_ff - y6_ff;
         end
         default: begin
            c_in = a_ff - y6_ff;
            b_in = c_in + x6_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
      end else if (en) begin
         v3_ff <= rot_valid;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ua_prod_ff <= ua_prod_in;
         ub_prod_ff <= ub_prod_in;
         ua_ff      <= ua_in;
         ub_ff      <= ub_in;
         x_ff       <= ub_ff;
         y_ff       <= y_in;
         z_ff       <= z_in;
         x6_ff      <= x_ff;
         y6_ff      <= y_ff;
         z6_ff      <= z_ff;
         a_ff       <= a_in;
         sector_ff  <= sector_in;
         cmp_a_ff   <= a_ff[CMP_W-1:0];
         cmp_b_ff   <= b_in[CMP_W-1:0];
         cmp_c_ff   <= c_in[CMP_W-1:0];
         sector7_ff <= sector_ff;
      end
   end

   assign rsp_tvalid = v7_ff;
   assign rsp_tdata  = {{(RSP_W-RSP_BITS){1'b0}}, sector7_ff, cmp_c_ff, cmp_b_ff, cmp_a_ff};

endmodule

/* rtl/ipsv_chk.sv */
module ipsv_chk
   import ipsv_pkg::*;
(
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tready,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [RSP_W-1:0]                    rsp_tdata,
   input logic                                csr_ready
);

   sector_type rsp_sector;

   assign rsp_sector = rsp_tdata[3*CMP_W +: SECTOR_W];

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   a_sector_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_sector >= SECTOR_1 && rsp_sector <= SECTOR_6))
      else $error("sector out of range");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("request taken while output stalled");

   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready && csr_ready)
      else $error("not ready with empty output");

endmodule

bind inverse_park_svpwm_duty ipsv_chk u_ipsv_chk (.*);

/* sim/inverse_park_svpwm_duty_test.sv */
`timescale 1ns / 1ps

module inverse_park_svpwm_duty_test;
   import ipsv_pkg::*;

   localparam int SAMPLE_W   = 16;
   localparam int FRAC       = SAMPLE_W - 1;
   localparam int REQ_W      = ((4 * SAMPLE_W + 7) / 8) * 8;
   localparam int PIPE_DEPTH = 7;

   typedef logic signed [SAMPLE_W-1:0] sample_type;

   // packed lowest field last: d_voltage sits in the low bits
   typedef struct packed {
      sample_type cosine_value;
      sample_type sine_value;
      sample_type q_voltage;
      sample_type d_voltage;
   } vdq_type;

   typedef struct packed {
      sector_type       sector;
      logic [CMP_W-1:0] phase_c;
      logic [CMP_W-1:0] phase_b;
      logic [CMP_W-1:0] phase_a;
   } duty_type;

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [REQ_W-1:0]    req_tdata  = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RSP_W-1:0]    rsp_tdata;
   logic                csr_valid  = 1'b0;
   logic                csr_ready;
   logic [PERIOD_W-1:0] csr_data   = '0;

   logic [PERIOD_W-1:0] period_count = PERIOD_RESET[PERIOD_W-1:0];
   duty_type            pending_duty[$];
   int                  error_count     = 0;
   bit                  tx_idle_en      = 1'b1;
   bit                  rx_idle_en      = 1'b1;
   int                  rx_hold_cycles  = 0;
   bit                  rx_holding      = 1'b0;

   inverse_park_svpwm_duty #(
      .SAMPLE_WIDTH(SAMPLE_W)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #5000000;
      $display("inverse_park_svpwm_duty regression: fail");
      $finish;
   end

   function automatic longint trunc_shift(input longint v, input int sh);
      return (v < 0) ? -((-v) >>> sh) : (v >>> sh);
   endfunction

   function automatic duty_type compute_duty(input vdq_type r, input logic [PERIOD_W-1:0] per);
      longint   d, q, s, c, t, alpha, beta, ua, ub, x, y, z, a, b, cc;
      sector_type sec;
      duty_type res;
      d = longint'($signed(r.d_voltage));
      q = longint'($signed(r.q_voltage));
      s = longint'($signed(r.sine_value));
      c = longint'($signed(r.cosine_value));
      t = longint'({1'b0, per});
      alpha = ((d * c) >>> FRAC) - ((q * s) >>> FRAC);
      beta  = ((d * s) >>> FRAC) + ((q * c) >>> FRAC);
      ua = trunc_shift(t * SQRT3_Q14 * alpha, FRAC + SQRT3_FRAC);
      ub = trunc_shift(-(t * beta), FRAC);
      x = ub;
      y = trunc_shift(ua + ub, 1);
      z = trunc_shift(ub - ua, 1);
      if (y < 0) begin
         if (z < 0) sec = SECTOR_5;
         else sec = (x > 0) ? SECTOR_3 : SECTOR_4;
      end else begin
         if (z < 0) sec = (x > 0) ? SECTOR_1 : SECTOR_6;
         else sec = SECTOR_2;
      end
      case (sec)
         SECTOR_1, SECTOR_4: begin
            a  = trunc_shift(2 * (t / 4) + t / 2 + x - z, 1);
            b  = a + z;
            cc = b - x;
         end
         SECTOR_2, SECTOR_5: begin
            a  = trunc_shift(2 * (t / 4) + t / 2 + y - z, 1);
            b  = a + z;
            cc = a - y;
         end
         default: begin
            a  = trunc_shift(2 * (t / 4) + t / 2 + y - x, 1);
            cc = a - y;
            b  = cc + x;
         end
      endcase
      res.phase_a = a[CMP_W-1:0];
      res.phase_b = b[CMP_W-1:0];
      res.phase_c = cc[CMP_W-1:0];
      res.sector  = sec;
      return res;
   endfunction

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic sample_type rand_sample();
      case ($urandom_range(0, 9))
         0:       return sample_type'(-32768);
         1:       return sample_type'(32767);
         2:       return '0;
         3:       return sample_type'($urandom_range(0, 8)) - sample_type'(4);
         default: return sample_type'($urandom);
      endcase
   endfunction

   task automatic send_request(input sample_type d, input sample_type q,
                               input sample_type s, input sample_type c);
      int gap;
      vdq_type r;
      r   = {c, s, q, d};
      gap = tx_idle_en ? pick_gap() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= r;
      do @(posedge clock); while (!req_tready);
      pending_duty.push_back(compute_duty(r, period_count));
   endtask

   task automatic send_random(input int count);
      repeat (count) send_request(rand_sample(), rand_sample(), rand_sample(), rand_sample());
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_duty.size() != 0) @(posedge clock);
      repeat (PIPE_DEPTH + 1) @(posedge clock);
   endtask

   task automatic write_period(input logic [PERIOD_W-1:0] value);
      wait_drained();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid    <= 1'b0;
      period_count = value;
   endtask

   task automatic test_directed();
      write_period(PERIOD_RESET[PERIOD_W-1:0]);
      send_request(16'sd0, 16'sd0, 16'sd0, 16'sd0);
      send_request(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
      send_request(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
      send_request(-16'sd32768, -16'sd32768, 16'sd32767, -16'sd32768);
      send_request(16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767);
      send_request(-16'sd32768, 16'sd32767, 16'sd32767, 16'sd32767);
      send_request(16'sd1, -16'sd1, -16'sd1, 16'sd1);
      send_request(-16'sd1, -16'sd1, -16'sd1, -16'sd1);
      // six vectors, rotated in 60 degree steps
      send_request(16'sd0, 16'sd20000, 16'sd16384, 16'sd28378);
      send_request(16'sd0, 16'sd20000, 16'sd32767, 16'sd0);
      send_request(16'sd0, 16'sd20000, 16'sd16384, -16'sd28378);
      send_request(16'sd0, 16'sd20000, -16'sd16384, -16'sd28378);
      send_request(16'sd0, 16'sd20000, -16'sd32768, 16'sd0);
      send_request(16'sd0, 16'sd20000, -16'sd16384, 16'sd28378);
   endtask

   task automatic test_period_extremes();
      logic [PERIOD_W-1:0] periods[6];
      periods = '{14'd16383, 14'd4, 14'd3, 14'd0, 14'd1, 14'd8191};
      foreach (periods[i]) begin
         write_period(periods[i]);
         send_request(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
         send_request(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
         send_request(-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767);
         send_request(16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768);
         send_random(12);
      end
   endtask

   task automatic test_random_periods();
      for (int i = 0; i < 6; i++) begin
         case (i)
            0:       write_period(14'd100);
            1:       write_period(14'd5);
            default: write_period(PERIOD_W'($urandom_range(4, 16383)));
         endcase
         send_random(130);
      end
   endtask

   task automatic test_back_to_back();
      write_period(PERIOD_W'($urandom_range(4, 16383)));
      tx_idle_en = 1'b0;
      rx_idle_en = 1'b0;
      send_random(100);
      tx_idle_en = 1'b1;
      rx_idle_en = 1'b1;
   endtask

   task automatic test_backpressure();
      wait_drained();
      tx_idle_en     = 1'b0;
      rx_hold_cycles = 120;
      while (!rx_holding) @(posedge clock);
      send_random(40);
      tx_idle_en = 1'b1;
      wait_drained();
   endtask

   // result side: random stalls, plus long hold-offs on request
   initial begin : rsp_driver
      int n;
      @(posedge clock);
      forever begin
         if (rx_hold_cycles > 0) begin
            n              = rx_hold_cycles;
            rx_hold_cycles = 0;
            rx_holding     = 1'b1;
            rsp_tready <= 1'b0;
            repeat (n) @(posedge clock);
            rx_holding = 1'b0;
         end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            n = pick_gap();
            repeat ((n < 1) ? 1 : n) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin : check_results
      duty_type got;
      duty_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[RSP_BITS-1:0];
         if (pending_duty.size() == 0) begin
            $display("%0t: unexpected response %h", $time, got);
            error_count++;
         end else begin
            want = pending_duty.pop_front();
            if (got.phase_a !== want.phase_a) begin
               $display("%0t: phase_a_compare expected %0d actual %0d", $time,
                        $signed(want.phase_a), $signed(got.phase_a));
               error_count++;
            end
            if (got.phase_b !== want.phase_b) begin
               $display("%0t: phase_b_compare expected %0d actual %0d", $time,
                        $signed(want.phase_b), $signed(got.phase_b));
               error_count++;
            end
            if (got.phase_c !== want.phase_c) begin
               $display("%0t: phase_c_compare expected %0d actual %0d", $time,
                        $signed(want.phase_c), $signed(got.phase_c));
               error_count++;
            end
            if (got.sector !== want.sector) begin
               $display("%0t: sector expected %0d actual %0d", $time,
                        want.sector, got.sector);
               error_count++;
            end
         end
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_period_extremes();
      test_random_periods();
      test_back_to_back();
      test_backpressure();
      wait_drained();
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("inverse_park_svpwm_duty regression: pass");
      end else begin
         $display("inverse_park_svpwm_duty regression: fail");
      end
      $finish;
   end

endmodule
